FILE: design/tlc_pkg.sv
// Shared widths, types and phase tables for the traffic light controller.
package tlc_pkg;

  localparam int SensorW    = 4;
  localparam int CarW       = 6;
  localparam int WalkW      = 2;
  localparam int PhaseW     = 3;
  localparam int TickW      = 8;
  localparam int DwellW     = 11;
  localparam int DwellUnitW = 3;
  localparam int NumPhases  = 7;
  localparam int NumReq     = 1 << SensorW;

  localparam logic [TickW-1:0] TicksPerUnitReset = TickW'(20);

  typedef logic [PhaseW-1:0]  phase_t;
  typedef logic [SensorW-1:0] flags_t;
  typedef logic [DwellW-1:0]  dwell_t;

  localparam phase_t PhaseMainGreen = phase_t'(0);

  localparam logic [CarW-1:0] CAR_TAB [NumPhases] = '{
    6'h0C, 6'h0C, 6'h0C, 6'h14, 6'h21, 6'h22, 6'h24
  };
  localparam logic [WalkW-1:0] WALK_TAB [NumPhases] = '{
    2'd0, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd3
  };
  localparam logic [DwellUnitW-1:0] DWELL_TAB [NumPhases] = '{
    3'd7, 3'd4, 3'd3, 3'd2, 3'd7, 3'd2, 3'd4
  };
  localparam flags_t CLEAR_TAB [NumPhases] = '{
    4'd8, 4'd1, 4'd8, 4'd0, 4'd4, 4'd0, 4'd3
  };
  localparam phase_t NEXT_TAB [NumPhases][NumReq] = '{
    '{3'd0, 3'd1, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd0, 3'd1, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3},
    '{3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2},
    '{3'd0, 3'd0, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd0, 3'd0, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3},
    '{3'd4, 3'd6, 3'd6, 3'd6, 3'd4, 3'd6, 3'd6, 3'd6,
      3'd4, 3'd6, 3'd6, 3'd6, 3'd4, 3'd6, 3'd6, 3'd6},
    '{3'd5, 3'd5, 3'd5, 3'd5, 3'd4, 3'd5, 3'd5, 3'd5,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5},
    '{3'd6, 3'd1, 3'd6, 3'd1, 3'd6, 3'd1, 3'd6, 3'd1,
      3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1},
    '{3'd0, 3'd0, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
      3'd0, 3'd0, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4}
  };

  // Map the unused phase code onto main-street green.
  function automatic phase_t safe_phase(phase_t p);
    phase_t r;
    r = (int'(p) < NumPhases) ? p : PhaseMainGreen;
    return r;
  endfunction

endpackage

FILE: design/tlc_intf.sv
// Valid/ready channel interfaces for sensor samples and light results.
interface tlc_sample_if import tlc_pkg::*; ();
  logic         valid;
  logic         ready;
  flags_t       sensors;

  modport source (output valid, output sensors, input ready);
  modport sink   (input valid, input sensors, output ready);
endinterface

interface tlc_result_if import tlc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CarW-1:0]  car_lights;
  logic [WalkW-1:0] walk_lights;
  phase_t          phase;
  logic            phase_changed;

  modport source (output valid, output car_lights, output walk_lights, output phase,
                  output phase_changed, input ready);
  modport sink   (input valid, input car_lights, input walk_lights, input phase,
                  input phase_changed, output ready);
endinterface

FILE: design/traffic_light_moore_controller.sv
// Seven-phase traffic light controller: one sample transaction in, one light result out.
// Each accepted sample transaction updates the controller state and loads one result
// into the output register; a new sample is taken every cycle as long as the output
// register is empty or is being drained in the same cycle, so throughput is one
// transaction per cycle, and each result is valid in the cycle after its sample.
// Sensor bits are latched into sticky request flags; a phase lasts its dwell units
// times ticks_per_unit samples, then its serviced flags are dropped and the next phase
// is looked up from the remaining flags. Write ticks_per_unit only while idle.
module traffic_light_moore_controller import tlc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  tlc_sample_if.sink          sample,
  tlc_result_if.source        result,
  input  logic                cfg_we,
  input  logic [TickW-1:0]    cfg_wdata
);

  logic [TickW-1:0] ticks_per_unit;
  phase_t           current_phase;
  dwell_t           dwell_ticks;
  flags_t           request_flags;

  logic [CarW-1:0]  car_lights;
  logic [WalkW-1:0] walk_lights;
  phase_t           phase_out;
  logic             phase_changed;
  logic             out_valid;

  phase_t           cur_p;
  dwell_t           target;
  dwell_t           dwell_inc;
  flags_t           flags_or;
  flags_t           clear_mask;
  logic             dwell_done;
  phase_t           phase_next;
  dwell_t           dwell_ticks_next;
  flags_t           request_flags_next;
  logic             accept;

  assign sample.ready = !out_valid || result.ready;
  assign accept       = sample.valid && sample.ready;

  always_comb begin
    cur_p      = safe_phase(current_phase);
    target     = DwellW'(DWELL_TAB[cur_p]) * DwellW'(ticks_per_unit);
    flags_or   = request_flags | sample.sensors;
    dwell_inc  = dwell_ticks + DwellW'(1);
    clear_mask = CLEAR_TAB[cur_p];
    dwell_done = (dwell_inc >= target);
    if (dwell_done) begin
      request_flags_next = flags_or & ~clear_mask;
      phase_next         = NEXT_TAB[cur_p][request_flags_next];
      dwell_ticks_next   = '0;
    end else begin
      request_flags_next = flags_or;
      phase_next         = cur_p;
      dwell_ticks_next   = dwell_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_unit <= TicksPerUnitReset;
    end else if (cfg_we) begin
      ticks_per_unit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_phase <= PhaseMainGreen;
      dwell_ticks   <= '0;
      request_flags <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        current_phase <= phase_next;
        dwell_ticks   <= dwell_ticks_next;
        request_flags <= request_flags_next;
        out_valid     <= 1'b1;
      end else if (result.ready) begin
        out_valid     <= 1'b0;
      end
    end
  end

  // Payload of the result register; load only on a new transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      car_lights    <= CAR_TAB[phase_next];
      walk_lights   <= WALK_TAB[phase_next];
      phase_out     <= phase_next;
      phase_changed <= dwell_done;
    end
  end

  assign result.valid         = out_valid;
  assign result.car_lights    = car_lights;
  assign result.walk_lights   = walk_lights;
  assign result.phase         = phase_out;
  assign result.phase_changed = phase_changed;

  a_result_after_accept : assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_valid && phase_out == current_phase))
    else $error("result register does not match phase after transaction");

  a_restart_on_change : assert property (@(posedge clk) disable iff (rst)
    (accept && dwell_done) |=> (dwell_ticks == '0))
    else $error("dwell counter not restarted after phase change");

  a_hold_phase_in_dwell : assert property (@(posedge clk) disable iff (rst)
    (accept && !dwell_done) |=> (current_phase == $past(cur_p) && !phase_changed))
    else $error("phase moved before dwell ended");

  a_serviced_flags_dropped : assert property (@(posedge clk) disable iff (rst)
    (accept && dwell_done) |=> ((request_flags & $past(clear_mask)) == '0))
    else $error("serviced request flags not cleared");

endmodule

FILE: verif/tb_traffic_light_moore_controller.sv
// Testbench for the traffic light controller: walks all phases, then random sensor ticks.
import tlc_pkg::*;

typedef enum logic [PhaseW-1:0] {
  PH_MAIN_GO,
  PH_MAIN_GO_WALK,
  PH_MAIN_GO_HOLD,
  PH_MAIN_AMBER,
  PH_SIDE_GO,
  PH_SIDE_AMBER,
  PH_ALL_RED_WALK
} lamp_phase_e;

typedef struct packed {
  logic [CarW-1:0]  car;
  logic [WalkW-1:0] walk;
  phase_t           phase;
  logic             changed;
} lights_t;

// Tracks the controller phase from accepted sensor ticks and matches the light results.
class phase_tracker;
  logic [TickW-1:0] ticks_per_unit;
  phase_t           cur_phase;
  dwell_t           dwell_cnt;
  flags_t           requests;
  lights_t          expected_lights[$];
  int               errors;

  function new();
    ticks_per_unit = 8'd20;
    cur_phase      = PH_MAIN_GO;
    dwell_cnt      = '0;
    requests       = '0;
    errors         = 0;
  endfunction

  function logic [CarW-1:0] car_lamps(phase_t p);
    // R1 Y1 G1 | R2 Y2 G2
    case (p)
      PH_MAIN_AMBER:   return 6'b010_100;
      PH_SIDE_GO:      return 6'b100_001;
      PH_SIDE_AMBER:   return 6'b100_010;
      PH_ALL_RED_WALK: return 6'b100_100;
      default:         return 6'b001_100;
    endcase
  endfunction

  function logic [WalkW-1:0] walk_lamps(phase_t p);
    case (p)
      PH_MAIN_GO_WALK: return 2'b01;
      PH_ALL_RED_WALK: return 2'b11;
      default:         return 2'b00;
    endcase
  endfunction

  function int unsigned dwell_units(phase_t p);
    case (p)
      PH_MAIN_GO_WALK: return 4;
      PH_MAIN_GO_HOLD: return 3;
      PH_MAIN_AMBER:   return 2;
      PH_SIDE_AMBER:   return 2;
      PH_ALL_RED_WALK: return 4;
      default:         return 7;
    endcase
  endfunction

  function flags_t serviced(phase_t p);
    case (p)
      PH_MAIN_GO_WALK: return 4'b0001;
      PH_MAIN_GO_HOLD: return 4'b1000;
      PH_MAIN_AMBER:   return 4'b0000;
      PH_SIDE_GO:      return 4'b0100;
      PH_SIDE_AMBER:   return 4'b0000;
      PH_ALL_RED_WALK: return 4'b0011;
      default:         return 4'b1000;
    endcase
  endfunction

  function phase_t follow_on(phase_t p, flags_t f);
    case (p)
      PH_MAIN_GO:
        return (f[2:1] != 2'b00) ? PH_MAIN_AMBER : (f[0] ? PH_MAIN_GO_WALK : PH_MAIN_GO);
      PH_MAIN_GO_WALK: return PH_MAIN_GO_HOLD;
      PH_MAIN_GO_HOLD: return (f[2:1] != 2'b00) ? PH_MAIN_AMBER : PH_MAIN_GO;
      PH_MAIN_AMBER:   return (f[1:0] != 2'b00) ? PH_ALL_RED_WALK : PH_SIDE_GO;
      PH_SIDE_GO:      return (f == 4'b0100) ? PH_SIDE_GO : PH_SIDE_AMBER;
      PH_SIDE_AMBER:
        return f[0] ? PH_MAIN_GO_WALK : (f[3] ? PH_MAIN_GO : PH_ALL_RED_WALK);
      default:         return (f[2:1] != 2'b00) ? PH_SIDE_GO : PH_MAIN_GO;
    endcase
  endfunction

  function void take_tick(flags_t s);
    lights_t     want;
    phase_t      p;
    int unsigned target;
    p         = (cur_phase > PH_ALL_RED_WALK) ? PH_MAIN_GO : cur_phase;
    target    = dwell_units(p) * ticks_per_unit;
    requests  = requests | s;
    dwell_cnt = dwell_cnt + 1'b1;
    want.changed = 1'b0;
    // The sample of the last tick counts before the serviced flags drop.
    if (dwell_cnt >= target) begin
      requests     = requests & ~serviced(p);
      cur_phase    = follow_on(p, requests);
      dwell_cnt    = '0;
      want.changed = 1'b1;
    end
    want.phase = cur_phase;
    want.car   = car_lamps(cur_phase);
    want.walk  = walk_lamps(cur_phase);
    expected_lights.push_back(want);
  endfunction

  function void note_error(string what, lights_t want, lights_t got);
    errors++;
    if (errors <= 10)
      $display({"%s: expected car=%h walk=%h phase=%0d changed=%b,",
                " got car=%h walk=%h phase=%0d changed=%b"},
               what, want.car, want.walk, want.phase, want.changed,
               got.car, got.walk, got.phase, got.changed);
  endfunction

  function void match_lights(lights_t got);
    lights_t want;
    if (expected_lights.size() == 0) begin
      note_error("unexpected result", '0, got);
      return;
    end
    want = expected_lights.pop_front();
    if (got.car !== want.car || got.walk !== want.walk ||
        got.phase !== want.phase || got.changed !== want.changed)
      note_error("lights mismatch", want, got);
  endfunction

  function int outstanding();
    return expected_lights.size();
  endfunction
endclass

module tb_traffic_light_moore_controller;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LongHold   = 80;
  localparam int StuckLimit = 1000;

  // Every phase in turn at zero ticks per unit: each tick ends a dwell.
  localparam flags_t PhaseWalk[18] = '{
    4'h0, 4'h0, 4'h1, 4'h0, 4'h2, 4'h0, 4'h0, 4'h4, 4'h0,
    4'h4, 4'h8, 4'hF, 4'h0, 4'h0, 4'h0, 4'h0, 4'h9, 4'h0
  };

  logic clk = 1'b0;
  logic rst;
  logic             cfg_we;
  logic [TickW-1:0] cfg_wdata;
  bit   sender_gaps = 1'b1;
  bit   hold_burst  = 1'b0;
  int   stuck_cycles = 0;

  phase_tracker tracker = new();

  tlc_sample_if sample_ch ();
  tlc_result_if result_ch ();

  traffic_light_moore_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly quiet ticks with a single request, so the flags do not saturate.
  function automatic flags_t pick_sensors();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 4'h0;
    if (r < 92) return flags_t'(1 << $urandom_range(0, 3));
    return flags_t'($urandom_range(0, 15));
  endfunction

  task automatic send_tick(flags_t s);
    int gap;
    gap = sender_gaps ? idle_len() : 0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.sensors <= s;
    do @(posedge clk); while (!sample_ch.ready);
    tracker.take_tick(s);
  endtask

  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_ticks_per_unit(logic [TickW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.ticks_per_unit = v;
  endtask

  task automatic run_random(int n);
    repeat (n) send_tick(pick_sensors());
  endtask

  initial begin : drain
    int len;
    forever begin
      if (hold_burst) begin
        // Hold off long enough for the output register to fill and stall the input.
        hold_burst = 1'b0;
        result_ch.ready <= 1'b0;
        len = LongHold;
      end else if ($urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        len = 1 + idle_len();
      end else begin
        result_ch.ready <= 1'b1;
        len = $urandom_range(1, 24);
      end
      repeat (len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      tracker.match_lights({result_ch.car_lights, result_ch.walk_lights,
                            result_ch.phase, result_ch.phase_changed});
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= StuckLimit) begin
      $display("** traffic_light_moore_controller: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    rst               <= 1'b1;
    sample_ch.valid   <= 1'b0;
    sample_ch.sensors <= '0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Two ticks at the reset rate, then drop to zero ticks per unit mid-dwell.
    send_tick(4'h0);
    send_tick(4'h0);
    settle();
    set_ticks_per_unit(8'd0);
    foreach (PhaseWalk[i]) send_tick(PhaseWalk[i]);

    settle();
    set_ticks_per_unit(8'd1);
    sender_gaps = 1'b0;
    hold_burst  = 1'b1;
    run_random(250);

    settle();
    set_ticks_per_unit(8'd2);
    sender_gaps = 1'b1;
    run_random(200);

    settle();
    set_ticks_per_unit(8'd0);
    run_random(120);

    settle();
    set_ticks_per_unit(8'd255);
    run_random(200);

    // Lower the rate well below the elapsed dwell; the next tick ends it.
    settle();
    set_ticks_per_unit(8'd1);
    run_random(120);

    settle();
    set_ticks_per_unit(8'($urandom_range(3, 12)));
    sender_gaps = 1'b0;
    run_random(160);

    settle();
    repeat (4) @(posedge clk);
    if (tracker.errors == 0)
      $display("** traffic_light_moore_controller: PASSED **");
    else
      $display("** traffic_light_moore_controller: FAILED **");
    $finish;
  end
endmodule
